// File: rtl/core/deq_pkg.sv
// Shared types, constants and helpers for the double-ended queue with search.
// Used by deq_front, deq_back, the top level and the port checker.
package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int VALUE_W    = 32;
    localparam int REQ_W      = 3;
    localparam int STAT_W     = 2;
    localparam int CFG_W      = 32;
    localparam int PADDR_W    = 3;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 40;

    // Register index, taken from paddr[2].
    localparam logic REG_MATCH_MASK = 1'b0;
    localparam logic [CFG_W-1:0] MATCH_MASK_RESET = '1;

    typedef enum logic [REQ_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5,
        OP_FIND       = 3'd6,
        OP_REMOVE     = 3'd7
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // Classified request as it travels from the front part to the back part.
    typedef struct packed {
        logic                  push;
        logic                  take;
        logic                  search;
        logic                  at_back;
        logic                  consume;
        logic [DATA_WIDTH-1:0] value;
    } req_t;

    // Ring position of the entry that lies off places behind base.
    // The offset never exceeds DEPTH, so one conditional subtract wraps it.
    function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W+1-IDX_W){1'b0}}, base} + {1'b0, off};
        if (sum >= (CNT_W+1)'(DEPTH)) begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// File: rtl/core/double_ended_queue_with_search_unit.sv
// Top level of the double-ended queue with search: configuration register,
// front part (deq_front) and back part (deq_back). Uses deq_pkg.
//
// Usage: requests enter on the s_axis stream, the operation code in tuser and
// the value or search key in tdata. Each request yields exactly one transfer on
// the m_axis stream carrying the result value, the current entry count and a
// status code. The match mask is written through the APB port at address 0
// while no request is in flight.
// A push or a refused request goes from the idle state straight to the result
// state; a pop or peek first reads the ring store, and a find or remove scans
// from the front entry. A remove that hits also closes the gap: the scan visits
// one entry per cycle and each later entry is moved forward in turn through the
// single write port of the ring store. The time the back part is busy with a
// request sets the spacing of results.
// The input side holds up to two requests in a queue, so it keeps accepting
// while the back part works; requests are executed one at a time.
// Reset empties the queue and the store and sets the match mask to all ones.
// When the receiver stalls, one finished result waits in the output register,
// the back part holds the next result, and the input queue fills and then
// drops tready.
module double_ended_queue_with_search_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [deq_pkg::S_TDATA_W-1:0] s_axis_tdata,  // item_value
    input  logic [deq_pkg::REQ_W-1:0]     s_axis_tuser,  // req_type
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [deq_pkg::M_TDATA_W-1:0] m_axis_tdata,  // result_value, item_count, zero pad
    output logic [deq_pkg::STAT_W-1:0]    m_axis_tuser,  // status
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [deq_pkg::PADDR_W-1:0]   paddr,
    input  logic [deq_pkg::CFG_W-1:0]     pwdata,
    output logic [deq_pkg::CFG_W-1:0]     prdata,
    output logic                          pready
);

    logic [deq_pkg::CFG_W-1:0]   match_mask_reg;
    logic                        q_valid;
    logic                        q_ready;
    deq_pkg::req_t               q_req;
    logic [deq_pkg::VALUE_W-1:0] res_value;
    deq_pkg::status_t            res_status;
    logic [deq_pkg::CNT_W-1:0]   res_count;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == deq_pkg::REG_MATCH_MASK) ? match_mask_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_mask_reg <= deq_pkg::MATCH_MASK_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == deq_pkg::REG_MATCH_MASK)) begin
            match_mask_reg <= pwdata;
        end
    end

    deq_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_req         (q_req)
    );

    deq_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .match_mask (deq_pkg::DATA_WIDTH'(match_mask_reg)),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_req      (q_req),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_value    (res_value),
        .m_status   (res_status),
        .m_count    (res_count)
    );

    assign m_axis_tdata = deq_pkg::M_TDATA_W'({res_count, res_value});
    assign m_axis_tuser = res_status;

endmodule

// File: rtl/core/deq_front.sv
// Front part: accepts requests from the input stream, decodes the operation
// and holds them in a two-entry queue for the back part. Uses deq_pkg.
module deq_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [deq_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic [deq_pkg::REQ_W-1:0]   s_axis_tuser,
    output logic                        q_valid,
    input  logic                        q_ready,
    output deq_pkg::req_t               q_req
);

    deq_pkg::req_t dec_req;
    deq_pkg::req_t q_mem [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    fill_reg;
    logic          do_push;
    logic          do_pop;

    always_comb begin
        dec_req         = '0;
        dec_req.value   = deq_pkg::DATA_WIDTH'(s_axis_tdata[deq_pkg::VALUE_W-1:0]);
        case (deq_pkg::op_t'(s_axis_tuser)) inside
            deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
                dec_req.push = 1'b1;
            end
            deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK,
            deq_pkg::OP_PEEK_FRONT, deq_pkg::OP_PEEK_BACK: begin
                dec_req.take = 1'b1;
            end
            default: begin
                dec_req.search = 1'b1;
            end
        endcase
        dec_req.at_back = (s_axis_tuser == deq_pkg::OP_PUSH_BACK) ||
                          (s_axis_tuser == deq_pkg::OP_POP_BACK) ||
                          (s_axis_tuser == deq_pkg::OP_PEEK_BACK);
        dec_req.consume = (s_axis_tuser == deq_pkg::OP_POP_FRONT) ||
                          (s_axis_tuser == deq_pkg::OP_POP_BACK) ||
                          (s_axis_tuser == deq_pkg::OP_REMOVE);
    end

    assign s_axis_tready = (fill_reg != 2'd2);
    assign q_valid       = (fill_reg != 2'd0);
    assign q_req         = q_mem[rd_ptr_reg];
    assign do_push       = s_axis_tvalid && s_axis_tready;
    assign do_pop        = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            q_mem[wr_ptr_reg] <= dec_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

// File: rtl/core/deq_back.sv
// Back part: owns the ring store, front index and count, carries out one
// request at a time and holds the result in an output register. Uses deq_pkg.
module deq_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [deq_pkg::DATA_WIDTH-1:0]  match_mask,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  deq_pkg::req_t                   q_req,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [deq_pkg::VALUE_W-1:0]     m_value,
    output deq_pkg::status_t                m_status,
    output logic [deq_pkg::CNT_W-1:0]       m_count
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_SHIFT = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    localparam int CNT_W = deq_pkg::CNT_W;
    localparam int IDX_W = deq_pkg::IDX_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(deq_pkg::DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO_CNT  = CNT_W'(2);

    state_t                        state_reg, state_next;
    logic [IDX_W-1:0]              front_reg, front_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [IDX_W-1:0]              k_reg, k_next;
    deq_pkg::req_t                 req_reg, req_next;
    logic [deq_pkg::DATA_WIDTH-1:0] res_reg, res_next;
    deq_pkg::status_t              stat_reg, stat_next;

    logic                          m_valid_reg;
    logic [deq_pkg::VALUE_W-1:0]   m_value_reg;
    deq_pkg::status_t              m_status_reg;
    logic [CNT_W-1:0]              m_count_reg;
    logic                          load_out;

    logic [deq_pkg::DATA_WIDTH-1:0] mem [deq_pkg::DEPTH];
    logic [deq_pkg::DATA_WIDTH-1:0] rd_data_reg;
    logic                          mem_we;
    logic [IDX_W-1:0]              mem_waddr;
    logic [IDX_W-1:0]              mem_raddr;
    logic [deq_pkg::DATA_WIDTH-1:0] mem_wdata;

    logic [IDX_W-1:0]              front_dec;
    logic [CNT_W-1:0]              k_ext;
    logic                          hit;
    logic                          last;

    assign front_dec = (front_reg == '0) ? IDX_W'(deq_pkg::DEPTH - 1) : front_reg - 1'b1;
    assign k_ext     = CNT_W'(k_reg);
    assign hit       = (((rd_data_reg ^ req_reg.value) & match_mask) == '0);
    assign last      = ((k_ext + ONE_CNT) == count_reg);

    always_comb begin
        state_next = state_reg;
        front_next = front_reg;
        count_next = count_reg;
        k_next     = k_reg;
        req_next   = req_reg;
        res_next   = res_reg;
        stat_next  = stat_reg;
        q_ready    = 1'b0;
        load_out   = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = front_reg;
        mem_wdata  = rd_data_reg;
        mem_raddr  = front_reg;

        case (state_reg)
            S_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    req_next   = q_req;
                    res_next   = '0;
                    stat_next  = deq_pkg::ST_OK;
                    state_next = S_RESP;
                    if (q_req.push) begin
                        if (count_reg == FULL_CNT) begin
                            stat_next = deq_pkg::ST_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_wdata = q_req.value;
                            if (q_req.at_back) begin
                                mem_waddr = deq_pkg::slot_add(front_reg, count_reg);
                            end else begin
                                mem_waddr  = front_dec;
                                front_next = front_dec;
                            end
                            count_next = count_reg + ONE_CNT;
                        end
                    end else if (q_req.take) begin
                        if (count_reg == '0) begin
                            stat_next = deq_pkg::ST_EMPTY;
                        end else begin
                            if (q_req.at_back) begin
                                mem_raddr = deq_pkg::slot_add(front_reg, count_reg - ONE_CNT);
                            end
                            state_next = S_READ;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            stat_next = deq_pkg::ST_NOTFOUND;
                        end else begin
                            k_next     = '0;
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_READ: begin
                res_next   = rd_data_reg;
                state_next = S_RESP;
                if (req_reg.consume) begin
                    count_next = count_reg - ONE_CNT;
                    if (!req_reg.at_back) begin
                        front_next = deq_pkg::slot_add(front_reg, ONE_CNT);
                    end
                end
            end
            S_SCAN: begin
                // The next entry is fetched every cycle, so the walk takes one
                // entry per cycle and a removal can start shifting at once.
                mem_raddr = deq_pkg::slot_add(front_reg, k_ext + ONE_CNT);
                if (hit) begin
                    res_next = rd_data_reg;
                    if (req_reg.consume && !last) begin
                        state_next = S_SHIFT;
                    end else begin
                        state_next = S_RESP;
                        if (req_reg.consume) begin
                            count_next = count_reg - ONE_CNT;
                        end
                    end
                end else if (last) begin
                    stat_next  = deq_pkg::ST_NOTFOUND;
                    state_next = S_RESP;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_SHIFT: begin
                // rd_data_reg holds the entry behind position k; move it forward.
                mem_we    = 1'b1;
                mem_waddr = deq_pkg::slot_add(front_reg, k_ext);
                mem_wdata = rd_data_reg;
                mem_raddr = deq_pkg::slot_add(front_reg, k_ext + TWO_CNT);
                k_next    = k_reg + 1'b1;
                if ((k_ext + TWO_CNT) >= count_reg) begin
                    count_next = count_reg - ONE_CNT;
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        k_reg   <= k_next;
        req_reg <= req_next;
        res_reg <= res_next;
        if (load_out) begin
            m_value_reg  <= deq_pkg::VALUE_W'(res_reg);
            m_status_reg <= stat_reg;
            m_count_reg  <= count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            front_reg   <= '0;
            count_reg   <= '0;
            stat_reg    <= deq_pkg::ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
            stat_reg  <= stat_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_value  = m_value_reg;
    assign m_status = m_status_reg;
    assign m_count  = m_count_reg;

endmodule

// File: rtl/core/deq_checker.sv
// Port checker for the double-ended queue with search, bound to the top level.
// Sees only the top-level ports. Uses deq_pkg.
module deq_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [deq_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [deq_pkg::STAT_W-1:0]    m_axis_tuser
);

    logic [deq_pkg::VALUE_W-1:0] value;
    logic [deq_pkg::CNT_W-1:0]   count;

    assign value = m_axis_tdata[deq_pkg::VALUE_W-1:0];
    assign count = m_axis_tdata[deq_pkg::VALUE_W+deq_pkg::CNT_W-1:deq_pkg::VALUE_W];

    // A stalled result transfer keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> count <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
        else $error("entry count above depth");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == deq_pkg::ST_EMPTY) |-> value == '0 && count == '0)
        else $error("empty status with data or entries");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == deq_pkg::ST_FULL) |->
            value == '0 && count == deq_pkg::CNT_W'(deq_pkg::DEPTH))
        else $error("full status with data or spare room");

    a_notfound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == deq_pkg::ST_NOTFOUND) |-> value == '0)
        else $error("not-found status with data");

endmodule

bind double_ended_queue_with_search_unit deq_checker u_deq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: dv/double_ended_queue_with_search_unit_test.sv
// Self-checking testbench for double_ended_queue_with_search_unit. Drives requests,
// writes the match mask and checks every result against its own deque predictor or
// a directed table row. It needs the package deq_pkg and the top level of the block.
`timescale 1ns / 1ps

module double_ended_queue_with_search_unit_test;
    import deq_pkg::*;

    localparam int ITEMS_PER_PHASE = 285;
    localparam int PHASES          = 6;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int REPORT_LIMIT    = 10;
    localparam logic [PADDR_W-1:0] MASK_ADDR = {REG_MATCH_MASK, 2'b00};

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        status_t            status;
        logic [CNT_W-1:0]   count;
    } deq_result_t;

    // One row of the directed table. A row with reps above one pushes value, value+1, ...
    typedef struct packed {
        op_t                op;
        logic [VALUE_W-1:0] value;
        logic [4:0]         reps;
        bit                 typed;
        logic [VALUE_W-1:0] exp_value;
        status_t            exp_status;
        logic [CNT_W-1:0]   exp_count;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 21;
    localparam stim_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
        '{OP_POP_FRONT,  32'h0000_0000,  5'd1, 1'b1, 32'h0000_0000, ST_EMPTY,    5'd0},
        '{OP_POP_BACK,   32'hFFFF_FFFF,  5'd1, 1'b1, 32'h0000_0000, ST_EMPTY,    5'd0},
        '{OP_PEEK_FRONT, 32'h0000_0000,  5'd1, 1'b1, 32'h0000_0000, ST_EMPTY,    5'd0},
        '{OP_PEEK_BACK,  32'h0000_0000,  5'd1, 1'b1, 32'h0000_0000, ST_EMPTY,    5'd0},
        '{OP_FIND,       32'h0000_0000,  5'd1, 1'b1, 32'h0000_0000, ST_NOTFOUND, 5'd0},
        '{OP_REMOVE,     32'hFFFF_FFFF,  5'd1, 1'b1, 32'h0000_0000, ST_NOTFOUND, 5'd0},
        '{OP_PUSH_BACK,  32'hFFFF_FFFF,  5'd1, 1'b1, 32'h0000_0000, ST_OK,       5'd1},
        '{OP_PUSH_FRONT, 32'h0000_0000,  5'd1, 1'b1, 32'h0000_0000, ST_OK,       5'd2},
        '{OP_PEEK_FRONT, 32'hFFFF_FFFF,  5'd1, 1'b1, 32'h0000_0000, ST_OK,       5'd2},
        '{OP_PEEK_BACK,  32'h0000_0000,  5'd1, 1'b1, 32'hFFFF_FFFF, ST_OK,       5'd2},
        '{OP_FIND,       32'hFFFF_FFFF,  5'd1, 1'b1, 32'hFFFF_FFFF, ST_OK,       5'd2},
        '{OP_FIND,       32'h7FFF_FFFF,  5'd1, 1'b1, 32'h0000_0000, ST_NOTFOUND, 5'd2},
        '{OP_REMOVE,     32'h0000_0000,  5'd1, 1'b1, 32'h0000_0000, ST_OK,       5'd1},
        '{OP_POP_BACK,   32'h0000_0000,  5'd1, 1'b1, 32'hFFFF_FFFF, ST_OK,       5'd0},
        '{OP_PUSH_FRONT, 32'h8000_0000, 5'd16, 1'b0, 32'h0000_0000, ST_OK,       5'd0},
        '{OP_PUSH_BACK,  32'h5A5A_5A5A,  5'd1, 1'b1, 32'h0000_0000, ST_FULL,     5'd16},
        '{OP_PUSH_FRONT, 32'hA5A5_A5A5,  5'd1, 1'b1, 32'h0000_0000, ST_FULL,     5'd16},
        '{OP_REMOVE,     32'h8000_0007,  5'd1, 1'b1, 32'h8000_0007, ST_OK,       5'd15},
        '{OP_PEEK_BACK,  32'h0000_0000,  5'd1, 1'b0, 32'h0000_0000, ST_OK,       5'd0},
        '{OP_POP_FRONT,  32'h0000_0000,  5'd1, 1'b0, 32'h0000_0000, ST_OK,       5'd0},
        '{OP_FIND,       32'h8000_0008,  5'd1, 1'b0, 32'h0000_0000, ST_OK,       5'd0}
    };

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata;
    logic [REQ_W-1:0]       s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic [STAT_W-1:0]      m_axis_tuser;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [CFG_W-1:0]       pwdata;
    logic [CFG_W-1:0]       prdata;
    logic                   pready;

    // Predictor state: stored values from front to back, and the match mask.
    logic [VALUE_W-1:0]     deque_model [$];
    logic [CFG_W-1:0]       mask_model;
    deq_result_t            pending_results [$];

    bit                     cur_typed;
    deq_result_t            cur_expect;
    int                     send_idle_pct;
    int                     recv_idle_pct;
    int                     quiet_left = 0;
    int                     error_count;
    int                     requests_seen;
    int                     results_seen;
    int                     status_tally [4];

    double_ended_queue_with_search_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 aclk = ~aclk;

    // Applies one request to the predictor state and returns the result it must give.
    function automatic deq_result_t apply_request(op_t op, logic [VALUE_W-1:0] v);
        deq_result_t r;
        int          n;
        int          k;
        r.value  = '0;
        r.status = ST_OK;
        n = deque_model.size();
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (n >= DEPTH) begin
                    r.status = ST_FULL;
                end else if (op == OP_PUSH_FRONT) begin
                    deque_model.push_front(v);
                end else begin
                    deque_model.push_back(v);
                end
            end
            OP_POP_FRONT, OP_PEEK_FRONT: begin
                if (n == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.value = deque_model[0];
                    if (op == OP_POP_FRONT) begin
                        void'(deque_model.pop_front());
                    end
                end
            end
            OP_POP_BACK, OP_PEEK_BACK: begin
                if (n == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.value = deque_model[n-1];
                    if (op == OP_POP_BACK) begin
                        void'(deque_model.pop_back());
                    end
                end
            end
            default: begin
                k = 0;
                while (k < n && ((deque_model[k] ^ v) & mask_model) != '0) begin
                    k++;
                end
                if (k >= n) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    r.value = deque_model[k];
                    if (op == OP_REMOVE) begin
                        deque_model.delete(k);
                    end
                end
            end
        endcase
        r.count = CNT_W'(deque_model.size());
        return r;
    endfunction

    // Both transfer sides are checked at the rising edge.
    always @(posedge aclk) begin : monitor
        deq_result_t got;
        deq_result_t want;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                want = apply_request(op_t'(s_axis_tuser), s_axis_tdata);
                if (cur_typed) begin
                    want = cur_expect;
                end
                pending_results.push_back(want);
                requests_seen++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.value  = m_axis_tdata[VALUE_W-1:0];
                got.status = status_t'(m_axis_tuser);
                got.count  = m_axis_tdata[VALUE_W +: CNT_W];
                results_seen++;
                status_tally[got.status]++;
                if (pending_results.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display("%0t: unexpected result value %h status %s count %0d",
                                 $realtime, got.value, got.status.name(), got.count);
                    end
                end else begin
                    want = pending_results.pop_front();
                    if (got != want) begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT) begin
                            $display("%0t: result mismatch, expected %h %s %0d, got %h %s %0d",
                                     $realtime, want.value, want.status.name(), want.count,
                                     got.value, got.status.name(), got.count);
                        end
                    end
                end
            end
        end
    end

    // Receiver stalls, with occasional quiet stretches where neither side idles.
    always @(negedge aclk) begin
        if (quiet_left > 0) begin
            quiet_left <= quiet_left - 1;
        end else if ($urandom_range(0, 299) == 0) begin
            quiet_left <= $urandom_range(20, 80);
        end
        m_axis_tready <= (quiet_left > 0) || ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial begin : watchdog
        int stuck_cycles;
        stuck_cycles = 0;
        while (stuck_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
            end
        end
        $display("double_ended_queue_with_search_unit_test failed");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(op_t op, logic [VALUE_W-1:0] v, bit typed, deq_result_t expect_r);
        while (quiet_left == 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        cur_typed     = typed;
        cur_expect    = expect_r;
        s_axis_tuser  <= op;
        s_axis_tdata  <= v;
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    task automatic write_match_mask(logic [CFG_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MASK_ADDR;
        pwdata  <= v;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        mask_model = v;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random request. Keys for find and remove mostly come from stored values, with
    // the unmasked bits scrambled, so that searches hit at every position.
    task automatic send_random_item(bit filling);
        op_t                op;
        logic [VALUE_W-1:0] v;
        int                 r;
        int                 n;
        deq_result_t        none;
        none = '0;
        n = deque_model.size();
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0) begin
            op = op_t'($urandom_range(0, 7));
        end else if (r < (filling ? 55 : 15)) begin
            op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        end else if (r < (filling ? 70 : 55)) begin
            op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
        end else if (r < (filling ? 78 : 63)) begin
            op = $urandom_range(0, 1) ? OP_PEEK_FRONT : OP_PEEK_BACK;
        end else if (r < (filling ? 90 : 80)) begin
            op = OP_FIND;
        end else begin
            op = OP_REMOVE;
        end
        r = $urandom_range(0, 99);
        if ((op == OP_FIND || op == OP_REMOVE) && n > 0 && r < 65) begin
            v = deque_model[$urandom_range(0, n - 1)] ^ ($urandom & ~mask_model);
        end else if (r < 75) begin
            v = $urandom;
        end else if (r < 90) begin
            v = VALUE_W'($urandom_range(0, 7));
        end else begin
            v = $urandom & 32'hF000_000F;
        end
        send_item(op, v, 1'b0, none);
    endtask

    initial begin : stimulus
        stim_row_t   row;
        deq_result_t typed_r;
        bit          filling;
        logic [CFG_W-1:0] mask;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_PUSH_FRONT;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        cur_typed     = 1'b0;
        cur_expect    = '0;
        error_count   = 0;
        requests_seen = 0;
        results_seen  = 0;
        status_tally  = '{0, 0, 0, 0};
        mask_model    = MATCH_MASK_RESET;
        send_idle_pct = 13;
        recv_idle_pct = 56;
        filling       = 1'b1;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            row = DIRECTED[i];
            typed_r.value  = row.exp_value;
            typed_r.status = row.exp_status;
            typed_r.count  = row.exp_count;
            for (int j = 0; j < row.reps; j++) begin
                send_item(row.op, row.value + VALUE_W'(j), row.typed, typed_r);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            case (p)
                0: mask = 32'hFFFF_FFFF;
                1: mask = 32'h0000_0000;
                2: mask = 32'h0000_00FF;
                4: mask = 32'hF000_000F;
                default: mask = $urandom;
            endcase
            write_match_mask(mask);
            case (p / 2)
                0: begin
                    send_idle_pct = 13;
                    recv_idle_pct = 56;
                end
                1: begin
                    send_idle_pct = 56;
                    recv_idle_pct = 13;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Swing between filling up and draining so both full and empty recur.
                if (deque_model.size() == DEPTH && $urandom_range(0, 2) == 0) begin
                    filling = 1'b0;
                end else if (deque_model.size() == 0) begin
                    filling = 1'b1;
                end else if ($urandom_range(0, 59) == 0) begin
                    filling = ~filling;
                end
                if (n == ITEMS_PER_PHASE / 2) begin
                    wait_drained();
                end
                send_random_item(filling);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            error_count++;
            $display("%0d expected results never arrived", pending_results.size());
        end
        $display("Covered %0d requests and %0d results over %0d mask settings and three idle mixes.",
                 requests_seen, results_seen, PHASES + 1);
        $display("Result statuses seen: ok %0d, empty %0d, full %0d, not found %0d.",
                 status_tally[ST_OK], status_tally[ST_EMPTY], status_tally[ST_FULL],
                 status_tally[ST_NOTFOUND]);
        if (error_count == 0) begin
            $display("double_ended_queue_with_search_unit_test passed");
        end else begin
            $display("double_ended_queue_with_search_unit_test failed");
        end
        $finish;
    end

endmodule
